FILE: design/cps_pkg.sv
// capsule pushout search package: shared widths, constants and command codes
// no dependencies

package cps_pkg;

  localparam int CoordW = 24;
  localparam int LenW   = 22;
  localparam int DepthW = 23;
  localparam int DistW  = 26;
  localparam int SqW    = 52;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic REG_CAMERA_RADIUS = 1'b0;
  localparam logic REG_CAPSULE_COUNT = 1'b1;

  localparam logic signed [CoordW-1:0] PushMax = 24'sh7FFFFF;
  localparam logic signed [CoordW-1:0] PushMin = -24'sh800000;

  typedef struct packed {
    logic signed [CoordW-1:0] bx;
    logic signed [CoordW-1:0] by;
    logic signed [CoordW-1:0] bz;
    logic [LenW-1:0]          r;
    logic [LenW-1:0]          h;
  } entry_t;

  // divider request and response
  typedef struct packed {
    logic                  start;
    logic [DistW+DepthW:0] num;
    logic [DistW-1:0]      den;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DistW+DepthW:0] quo;
  } div_rsp_t;

endpackage

FILE: design/cps_table.sv
// capsule table: synchronous memory with one write and one registered read port
// depends on cps_pkg

module cps_table #(
  parameter int Depth = 16,
  parameter int AW = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  cps_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output cps_pkg::entry_t rdata
);

  cps_pkg::entry_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/cps_sqrt.sv
// restoring integer square root, two radicand bits per cycle
// depends on cps_pkg

module cps_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [cps_pkg::SqW-1:0]      v,
  output logic                         done,
  output logic [cps_pkg::DistW-1:0]    root
);

  localparam int Steps = cps_pkg::SqW / 2;

  logic [cps_pkg::SqW-1:0]   rad;
  logic [cps_pkg::DistW+1:0] rem;
  logic [5:0]                cnt;
  logic                      busy;
  logic [cps_pkg::DistW+1:0] trial;
  logic [cps_pkg::DistW+1:0] rem_sh;

  always_comb begin
    rem_sh = {rem[cps_pkg::DistW-1:0], rad[cps_pkg::SqW-1 -: 2]};
    trial  = {root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rad  <= v;
        rem  <= '0;
        root <= '0;
        cnt  <= '0;
      end else if (busy) begin
        rad <= {rad[cps_pkg::SqW-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[cps_pkg::DistW-2:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[cps_pkg::DistW-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(Steps - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: design/cps_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on cps_pkg

module cps_div (
  input  logic              clk,
  input  logic              rst,
  input  cps_pkg::div_req_t req,
  output cps_pkg::div_rsp_t rsp
);

  localparam int NW = cps_pkg::DistW + cps_pkg::DepthW + 1;

  logic [NW-1:0]              num;
  logic [cps_pkg::DistW-1:0]  den;
  logic [cps_pkg::DistW:0]    rem;
  logic [6:0]                 cnt;
  logic                       busy;
  logic                       done;
  logic [cps_pkg::DistW:0]    rem_sh;

  assign rem_sh = {rem[cps_pkg::DistW-1:0], num[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        num  <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        if (rem_sh >= {1'b0, den}) begin
          rem <= rem_sh - {1'b0, den};
          num <= {num[NW-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          num <= {num[NW-2:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, quo: num};

endmodule

FILE: design/capsule_pushout_search.sv
// Capsule pushout search. A write item stores one capsule. A query item walks the table one
// capsule at a time: a memory read, the squares, the square-root unit for each capsule whose
// padded height band holds the point, and for each new deepest capsule off its axis two
// passes through the shared divider, one for x and one for z. The result waits in an output
// register; the next item is taken once that register is free or being emptied.
// depends on cps_pkg, cps_table, cps_sqrt, cps_div

module capsule_pushout_search #(
  parameter int MAX_CAPSULES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [3:0]  entry_index,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic [21:0] capsule_radius,
  input  logic [21:0] capsule_height,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [23:0] push_x,
  output logic signed [23:0] push_z,
  output logic [22:0] depth,
  output logic        inside_res
);

  localparam int AW = (MAX_CAPSULES > 1) ? $clog2(MAX_CAPSULES) : 1;
  localparam int CW = $clog2(MAX_CAPSULES + 1);
  localparam int DW = cps_pkg::DistW;
  localparam int NW = cps_pkg::DistW + cps_pkg::DepthW + 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_SQ = 3'd2, S_ROOT = 3'd3,
                         S_DIVX = 3'd4, S_DIVZ = 3'd5, S_DONE = 3'd6;

  localparam logic signed [25:0] PushMaxExt = 26'sd8388607;
  localparam logic signed [25:0] PushMinExt = -26'sd8388608;

  logic [2:0]    state;
  logic [15:0]   cam_r;
  logic [4:0]    cnt_reg;
  logic [CW-1:0] n_use;
  logic [CW-1:0] idx;
  logic signed [23:0] qx, qy, qz;
  cps_pkg::entry_t ent, wentry;
  logic signed [24:0] dx, dz;
  logic signed [24:0] dx_c, dz_c;
  logic [22:0]   r_cur;
  logic [cps_pkg::SqW-1:0] d2;
  logic          root_done;
  logic [DW-1:0] root;
  logic [DW-1:0] planar;
  logic [23:0]   deep;
  logic signed [25:0] best_px, best_pz;
  cps_pkg::div_req_t dreq;
  cps_pkg::div_rsp_t drsp;
  logic          we;
  logic [AW-1:0] raddr;
  logic signed [25:0] above;
  logic          in_band;
  logic signed [27:0] inside_v;
  logic [NW-1:0] numx;
  logic          neg;
  logic signed [25:0] quo_s;
  logic signed [23:0] sat_v;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign we = in_valid && in_ready && (command == cps_pkg::CMD_WRITE)
              && (32'(entry_index) < MAX_CAPSULES);
  assign wentry = '{bx: pos_x, by: pos_y, bz: pos_z, r: capsule_radius, h: capsule_height};
  assign raddr = AW'(idx);
  assign n_use = (32'(cnt_reg) > MAX_CAPSULES) ? CW'(MAX_CAPSULES) : CW'(cnt_reg);

  cps_table #(.Depth(MAX_CAPSULES), .AW(AW)) u_table (
    .clk(clk), .we(we), .waddr(AW'(entry_index)), .wdata(wentry),
    .raddr(raddr), .rdata(ent)
  );

  cps_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(state == S_SQ), .v(d2), .done(root_done), .root(root)
  );

  cps_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_comb begin
    above = 26'(qy) - 26'(ent.by);
    in_band = (above >= -$signed({4'd0, ent.r}))
              && (above <= $signed({3'd0, ent.h} + {3'd0, ent.r}));
    inside_v = $signed({5'd0, r_cur}) + $signed({12'd0, cam_r}) - $signed({2'd0, root});
  end

  // divider operand: |d| * depth, sign handled outside
  always_comb begin
    if (state == S_DIVX || (state == S_ROOT && root_done)) begin
      neg = dx[24];
    end else begin
      neg = dz[24];
    end
    dreq.start = 1'b0;
    dreq.den = (state == S_ROOT) ? root : planar;
    numx = NW'((neg ? 25'(-dx) : 25'(dx)));
    if (state == S_DIVX) begin
      numx = NW'((dz[24] ? 25'(-dz) : 25'(dz)));
    end
    dreq.num = NW'(numx[24:0] * (state == S_ROOT ? 24'(inside_v) : deep));
    if (state == S_ROOT && root_done && inside_v > 0 && inside_v > $signed({4'd0, deep})
        && root != '0) begin
      dreq.start = 1'b1;
    end
    if (state == S_DIVX && drsp.done) begin
      dreq.start = 1'b1;
    end
    quo_s = 26'(drsp.quo[24:0]);
    if (state == S_DIVX ? dx[24] : dz[24]) begin
      quo_s = -quo_s;
    end
    if (quo_s > 26'(PushMaxExt)) sat_v = cps_pkg::PushMax;
    else if (quo_s < 26'(PushMinExt)) sat_v = cps_pkg::PushMin;
    else sat_v = 24'(quo_s);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cam_r     <= 16'd128;
      cnt_reg   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          cps_pkg::REG_CAMERA_RADIUS: cam_r   <= cfg_data;
          cps_pkg::REG_CAPSULE_COUNT: cnt_reg <= cfg_data[4:0];
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready && command == cps_pkg::CMD_QUERY) begin
            qx <= pos_x; qy <= pos_y; qz <= pos_z;
            idx <= '0;
            deep <= '0;
            best_px <= '0; best_pz <= '0;
            state <= S_READ;
          end
        end
        S_READ: begin
          if (idx >= n_use) state <= S_DONE;
          else state <= S_SQ;
        end
        S_SQ: begin
          dx <= dx_c;
          dz <= dz_c;
          r_cur <= {1'b0, ent.r};
          if (!in_band) begin
            idx <= idx + CW'(1);
            state <= S_READ;
          end else begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            if (inside_v > 0 && inside_v > $signed({4'd0, deep})) begin
              deep <= 24'(inside_v);
              planar <= root;
              if (root == '0) begin
                best_px <= (inside_v > 28'(PushMaxExt)) ? PushMaxExt : 26'(inside_v);
                best_pz <= '0;
                idx <= idx + CW'(1);
                state <= S_READ;
              end else begin
                state <= S_DIVX;
              end
            end else begin
              idx <= idx + CW'(1);
              state <= S_READ;
            end
          end
        end
        S_DIVX: begin
          if (drsp.done) begin
            best_px <= 26'(sat_v);
            state <= S_DIVZ;
          end
        end
        S_DIVZ: begin
          if (drsp.done) begin
            best_pz <= 26'(sat_v);
            idx <= idx + CW'(1);
            state <= S_READ;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            push_x     <= 24'(best_px);
            push_z     <= 24'(best_pz);
            depth      <= deep[22:0];
            inside_res <= deep != '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign dx_c = 25'(qx) - 25'(ent.bx);
  assign dz_c = 25'(qz) - 25'(ent.bz);
  assign d2 = cps_pkg::SqW'(dx_c * dx_c) + cps_pkg::SqW'(dz_c * dz_c);

  ap_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ready) else $error("item accepted while busy");
  ap_depth_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (inside_res == (depth != '0))) else $error("inside flag mismatch");
  ap_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(depth)) else $error("result lost");

endmodule

FILE: test/capsule_pushout_search_test.sv
// testbench for capsule_pushout_search: capsule writes and point queries with random stalls
// a scoreboard class predicts each query result and checks the block's output
// depends on cps_pkg and capsule_pushout_search
`timescale 1ns / 1ps

module capsule_pushout_search_test;

  typedef struct {
    logic signed [cps_pkg::CoordW-1:0] px;
    logic signed [cps_pkg::CoordW-1:0] pz;
    logic [cps_pkg::DepthW-1:0]        dep;
    logic                              ins;
  } push_t;

  class pushout_board;
    cps_pkg::entry_t tbl [16];
    logic [15:0] cam;
    logic [4:0]  cnt;
    push_t       pending [$];
    int          errors;

    function new();
      cam = 16'd128;
      cnt = 5'd0;
      errors = 0;
      for (int i = 0; i < 16; i++) tbl[i] = '0;
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endfunction

    function void set_reg(logic idx, logic [15:0] data);
      if (idx == cps_pkg::REG_CAMERA_RADIUS) cam = data;
      else cnt = data[4:0];
    endfunction

    function longint unsigned root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint clip24(longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
    endfunction

    function void note(logic cmd, logic [3:0] idx, logic signed [23:0] x,
                       logic signed [23:0] y, logic signed [23:0] z,
                       logic [21:0] r, logic [21:0] h);
      int n;
      longint deep, sx, sz, rr, above, dx, dz, ins;
      longint unsigned pl;
      push_t e;
      if (cmd == cps_pkg::CMD_WRITE) begin
        tbl[idx] = '{bx: x, by: y, bz: z, r: r, h: h};
        return;
      end
      n = (cnt > 16) ? 16 : cnt;
      deep = 0; sx = 0; sz = 0;
      for (int i = 0; i < n; i++) begin
        rr = longint'(tbl[i].r);
        above = longint'(y) - longint'(tbl[i].by);
        if (above < -rr || above > longint'(tbl[i].h) + rr) continue;
        dx = longint'(x) - longint'(tbl[i].bx);
        dz = longint'(z) - longint'(tbl[i].bz);
        pl = root_floor(longint'(dx * dx + dz * dz));
        ins = rr + longint'(cam) - longint'(pl);
        if (ins <= 0 || ins <= deep) continue;
        deep = ins;
        if (pl > 0) begin
          sx = clip24((dx * ins) / longint'(pl));
          sz = clip24((dz * ins) / longint'(pl));
        end else begin
          sx = clip24(ins);
          sz = 0;
        end
      end
      e.px = sx[23:0];
      e.pz = sz[23:0];
      e.dep = deep[22:0];
      e.ins = deep > 0;
      pending.push_back(e);
    endfunction

    function void check(logic signed [23:0] px, logic signed [23:0] pz,
                        logic [22:0] dep, logic ins);
      push_t e;
      if (pending.size() == 0) begin
        report("result with no query waiting");
        return;
      end
      e = pending.pop_front();
      if (px !== e.px) report($sformatf("push_x %0d, predicted %0d", px, e.px));
      if (pz !== e.pz) report($sformatf("push_z %0d, predicted %0d", pz, e.pz));
      if (dep !== e.dep) report($sformatf("depth %0d, predicted %0d", dep, e.dep));
      if (ins !== e.ins) report($sformatf("inside_res %0b, predicted %0b", ins, e.ins));
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [15:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic command = 0;
  logic [3:0] entry_index = '0;
  logic signed [23:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic [21:0] capsule_radius = '0, capsule_height = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [23:0] push_x, push_z;
  logic [22:0] depth;
  logic inside_res;

  pushout_board board = new();
  int send_idle = 0;
  int recv_stall = 0;

  capsule_pushout_search u_top (.*);

  always #1 clk = ~clk;

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk)
    if (!rst && out_valid && out_ready) board.check(push_x, push_z, depth, inside_res);

  initial begin
    #40_000_000;
    $display("capsule_pushout_search_test failed");
    $finish;
  end

  task automatic send_item(logic cmd, logic [3:0] idx, logic signed [23:0] x,
                           logic signed [23:0] y, logic signed [23:0] z,
                           logic [21:0] r, logic [21:0] h);
    in_valid = 1;
    command = cmd; entry_index = idx;
    pos_x = x; pos_y = y; pos_z = z;
    capsule_radius = r; capsule_height = h;
    do @(posedge clk); while (!in_ready);
    board.note(cmd, idx, x, y, z, r, h);
    @(negedge clk);
    in_valid = 0;
    while ($urandom_range(99) < send_idle) @(negedge clk);
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    drain();
    cfg_we = 1; cfg_index = idx; cfg_data = data;
    @(negedge clk);
    cfg_we = 0;
    board.set_reg(idx, data);
  endtask

  task automatic put_capsule(logic [3:0] idx);
    send_item(cps_pkg::CMD_WRITE, idx, 24'($urandom_range(200000) - 100000),
              24'($urandom_range(200000) - 100000), 24'($urandom_range(200000) - 100000),
              22'($urandom_range(4000)), 22'($urandom_range(8000)));
  endtask

  // point near a capsule in use, inside or just outside its padded band
  task automatic near_query();
    int n, s, reach;
    cps_pkg::entry_t c;
    n = (board.cnt > 16) ? 16 : board.cnt;
    s = (n == 0) ? 0 : $urandom_range(n - 1);
    c = board.tbl[s];
    reach = int'(c.r) + int'(board.cam) + 8;
    if (reach > 200000) reach = 200000;
    if ($urandom_range(9) == 0)
      send_item(cps_pkg::CMD_QUERY, 4'($urandom), c.bx, 24'(c.by + $urandom_range(c.h)),
                c.bz, 22'($urandom), 22'($urandom));
    else
      send_item(cps_pkg::CMD_QUERY, 4'($urandom),
                24'(c.bx + $urandom_range(2 * reach) - reach),
                24'(c.by + $urandom_range(int'(c.h) + 2 * int'(c.r) + 10) - int'(c.r) - 5),
                24'(c.bz + $urandom_range(2 * reach) - reach),
                22'($urandom), 22'($urandom));
  endtask

  initial begin
    int cams [4];
    int cnts [5];
    int items, k;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: extremes, equal capsules for the tie, on-axis and clear points
    send_item(cps_pkg::CMD_WRITE, 4'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
              22'h3FFFFF, 22'h3FFFFF);
    send_item(cps_pkg::CMD_WRITE, 4'd1, -24'sh800000, -24'sh800000, -24'sh800000,
              22'd0, 22'd0);
    send_item(cps_pkg::CMD_WRITE, 4'd2, 24'sd1000, 24'sd0, -24'sd2000, 22'd700, 22'd3000);
    send_item(cps_pkg::CMD_WRITE, 4'd3, 24'sd1000, 24'sd0, -24'sd2000, 22'd700, 22'd3000);
    for (int i = 4; i < 16; i++) put_capsule(4'(i));
    write_reg(cps_pkg::REG_CAPSULE_COUNT, 16'd16);
    send_item(cps_pkg::CMD_QUERY, 4'hF, 24'sd1000, 24'sd100, -24'sd2000,
              22'h3FFFFF, 22'h3FFFFF);
    send_item(cps_pkg::CMD_QUERY, 4'd0, 24'sd1300, -24'sd700, -24'sd1600, 22'd0, 22'd0);
    send_item(cps_pkg::CMD_QUERY, 4'd0, 24'sd1000, 24'sd3827, -24'sd1200, 22'd0, 22'd0);
    send_item(cps_pkg::CMD_QUERY, 4'd0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 22'd0, 22'd0);
    send_item(cps_pkg::CMD_QUERY, 4'd0, 24'sh700000, 24'sh700000, 24'sh7F0000, 22'd0, 22'd0);
    send_item(cps_pkg::CMD_QUERY, 4'd0, -24'sh800000, -24'sh800000, -24'sh800000,
              22'd0, 22'd0);
    write_reg(cps_pkg::REG_CAMERA_RADIUS, 16'hFFFF);
    send_item(cps_pkg::CMD_QUERY, 4'd0, 24'sd1000, 24'sd0, -24'sd2000, 22'd0, 22'd0);
    send_item(cps_pkg::CMD_QUERY, 4'd0, 24'sh7FFFFF, 24'sh000000, 24'sh7FFFFF, 22'd0, 22'd0);
    write_reg(cps_pkg::REG_CAPSULE_COUNT, 16'd0);
    send_item(cps_pkg::CMD_QUERY, 4'd0, 24'sd1000, 24'sd0, -24'sd2000, 22'd0, 22'd0);

    cams = '{0, 65535, 128, 0};
    for (int mode = 0; mode < 4; mode++) begin
      send_idle  = (mode == 1 || mode == 3) ? ((mode == 3) ? 34 : 50) : 0;
      recv_stall = (mode == 2 || mode == 3) ? ((mode == 3) ? 34 : 50) : 0;
      cnts = '{$urandom_range(1, 4), 0, 16, 31, $urandom_range(1, 6)};
      for (int s = 0; s < 5; s++) begin
        write_reg(cps_pkg::REG_CAMERA_RADIUS,
                  16'((s == 4) ? $urandom : cams[(mode + s) % 4]));
        write_reg(cps_pkg::REG_CAPSULE_COUNT, {11'($urandom_range(2047)), cnts[s][4:0]});
        items = (cnts[s] >= 16) ? 15 : 80;
        for (int i = 0; i < items; i++) begin
          k = $urandom_range(99);
          if (mode == 2 && s == 1 && i == 30) drain();
          if (k < 20) put_capsule(4'($urandom));
          else if (k < 25)
            send_item(cps_pkg::CMD_WRITE, 4'($urandom), 24'($urandom), 24'($urandom),
                      24'($urandom), 22'($urandom), 22'($urandom));
          else if (k < 32)
            send_item(cps_pkg::CMD_QUERY, 4'($urandom), 24'($urandom), 24'($urandom),
                      24'($urandom), 22'($urandom), 22'($urandom));
          else near_query();
        end
      end
    end

    drain();
    repeat (100) @(negedge clk);
    if (board.errors == 0) $display("capsule_pushout_search_test passed");
    else $display("capsule_pushout_search_test failed");
    $finish;
  end

endmodule

FILE: files.f
design/cps_pkg.sv
design/cps_table.sv
design/cps_sqrt.sv
design/cps_div.sv
design/capsule_pushout_search.sv
test/capsule_pushout_search_test.sv
